// ===== design/cvpe_pkg.sv =====
// Shared types, constants and helper functions for the constant-velocity
// path extrapolator. No dependencies.
package cvpe_pkg;

  localparam int MAX_STEPS     = 64;
  localparam int HISTORY_FULL  = 50;
  localparam int CNT_W         = 6;
  localparam int CFG_W         = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int POS_W         = 32;
  localparam int DELTA_W       = POS_W + 1;
  localparam int ACC_W         = 40;
  localparam int SPEED_W       = DELTA_W + CFG_W;

  localparam logic [CFG_W-1:0]     FALLBACK_RATE = 7'd10;
  localparam logic [CFG_W-1:0]     RESET_RATE    = 7'd10;
  localparam logic [CFG_W-1:0]     RESET_HORIZON = 7'd3;
  localparam logic [SPEED_W-1:0]   HALF_Q16      = SPEED_W'(32768);
  localparam logic [32:0]          QUARTER_Q32   = 33'd1073741824;

  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_SECOND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZON_SECONDS  = 2'd1;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_SQR,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_t;

  // One queued prediction run
  typedef struct packed {
    logic signed [POS_W-1:0]   newest_x;
    logic signed [POS_W-1:0]   newest_y;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [CFG_W-1:0]          steps;
    logic [CFG_W-1:0]          conf;
    logic                      has_pts;
  } job_t;

  // count * 100 / HISTORY_FULL, capped at 100; a constant table over every count
  function automatic logic [CFG_W-1:0] conf_of(input logic [CNT_W-1:0] cnt);
    logic [CFG_W-1:0] v;
    v = '0;
    for (int i = 0; i < (1 << CNT_W); i++) begin
      if (cnt == CNT_W'(i)) begin
        v = CFG_W'(((i * 100) / HISTORY_FULL > 100) ? 100 : (i * 100) / HISTORY_FULL);
      end
    end
    return v;
  endfunction

  // Clamp a wide signed value to 32-bit two's complement
  function automatic logic [POS_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-POS_W:0] top;
    top = v[ACC_W-1:POS_W-1];
    if (top == '0 || top == '1) begin
      return v[POS_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== design/cvpe_front.sv =====
// Front end: takes position samples, keeps history, works out velocity,
// speed class, confidence and step count, and queues a job. Uses cvpe_pkg.
module cvpe_front
  import cvpe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [POS_W-1:0] in_x,
  input  logic signed [POS_W-1:0] in_y,
  input  logic                  in_restart,
  input  logic [CFG_W-1:0]      rate_cfg,
  input  logic [CFG_W-1:0]      horizon_cfg,
  output logic                  push_valid,
  input  logic                  push_ready,
  output job_t                  push_job
);

  front_state_t state_r, state_nxt;

  logic signed [POS_W-1:0]   newest_x_r, newest_y_r;
  logic [CNT_W-1:0]          count_r, count_nxt, count_base;
  logic signed [DELTA_W-1:0] dx_r, dy_r;
  logic [CFG_W-1:0]          rate_r, steps_r, conf_r;
  logic                      short_r;
  logic [SPEED_W-1:0]        dxa_r, dya_r;
  logic [31:0]               sqx_r, sqy_r;
  logic                      big_r;

  logic [CFG_W-1:0]      rate_eff;
  logic [2*CFG_W-1:0]    steps_wide;
  logic [CFG_W-1:0]      steps_cap;
  logic [DELTA_W-1:0]    dx_abs, dy_abs;
  logic [32:0]           sq_sum;
  logic                  fast;
  logic [CFG_W-1:0]      conf_out;

  assign count_base = in_restart ? '0 : count_r;
  assign count_nxt  = (count_base < CNT_W'(HISTORY_FULL)) ? count_base + 1'b1 : count_base;
  assign rate_eff   = (rate_cfg == '0) ? FALLBACK_RATE : rate_cfg;
  assign steps_wide = (2*CFG_W)'(horizon_cfg) * (2*CFG_W)'(rate_eff);
  assign steps_cap  = (steps_wide > (2*CFG_W)'(MAX_STEPS)) ? CFG_W'(MAX_STEPS)
                                                           : steps_wide[CFG_W-1:0];

  assign dx_abs = dx_r[DELTA_W-1] ? DELTA_W'(-dx_r) : DELTA_W'(dx_r);
  assign dy_abs = dy_r[DELTA_W-1] ? DELTA_W'(-dy_r) : DELTA_W'(dy_r);

  assign sq_sum   = 33'(sqx_r) + 33'(sqy_r);
  assign fast     = big_r || (sq_sum > QUARTER_Q32);
  assign conf_out = short_r ? '0 : (fast ? conf_r : (conf_r >> 1));

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    push_valid = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = F_MUL;
        end
      end
      F_MUL:  state_nxt = F_SQR;
      F_SQR:  state_nxt = F_PUSH;
      F_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // History lives here; it updates as each word is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_x_r <= '0;
      newest_y_r <= '0;
      count_r    <= '0;
    end else if (state_r == F_IDLE && in_valid) begin
      newest_x_r <= in_x;
      newest_y_r <= in_y;
      count_r    <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_valid) begin
      dx_r    <= DELTA_W'(in_x) - DELTA_W'(newest_x_r);
      dy_r    <= DELTA_W'(in_y) - DELTA_W'(newest_y_r);
      rate_r  <= rate_eff;
      steps_r <= steps_cap;
      conf_r  <= conf_of(count_nxt);
      short_r <= (count_nxt < CNT_W'(2));
    end
    if (state_r == F_MUL) begin
      dxa_r <= SPEED_W'(dx_abs) * SPEED_W'(rate_r);
      dya_r <= SPEED_W'(dy_abs) * SPEED_W'(rate_r);
    end
    if (state_r == F_SQR) begin
      big_r <= (dxa_r > HALF_Q16) || (dya_r > HALF_Q16);
      sqx_r <= dxa_r[15:0] * dxa_r[15:0];
      sqy_r <= dya_r[15:0] * dya_r[15:0];
    end
  end

  always_comb begin
    push_job.newest_x = newest_x_r;
    push_job.newest_y = newest_y_r;
    push_job.dx       = dx_r;
    push_job.dy       = dy_r;
    push_job.steps    = steps_r;
    push_job.conf     = conf_out;
    push_job.has_pts  = !short_r && (steps_r != '0);
  end

endmodule

// ===== design/cvpe_queue.sv =====
// Two-entry job queue between front and back end. Uses cvpe_pkg.
module cvpe_queue
  import cvpe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  job_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;
  logic       do_push, do_pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_job    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== design/cvpe_back.sv =====
// Back end: walks one queued job, one predicted point per cycle while the
// output is not stalled, into an output register. Uses cvpe_pkg.
module cvpe_back
  import cvpe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  job_t               pop_job,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [POS_W-1:0]   out_x,
  output logic [POS_W-1:0]   out_y,
  output logic [CFG_W-1:0]   out_k,
  output logic               out_has,
  output logic [CFG_W-1:0]   out_conf,
  output logic               out_last
);

  back_state_t state_r, state_nxt;

  job_t                    job_r;
  logic signed [ACC_W-1:0] acc_x_r, acc_y_r;
  logic [CFG_W-1:0]        k_r;
  logic                    valid_r;
  logic [POS_W-1:0]        x_r, y_r;
  logic [CFG_W-1:0]        ko_r, conf_r;
  logic                    has_r, last_r;

  logic advance, is_last;

  assign advance  = (state_r == B_RUN) && (!valid_r || out_ready);
  assign is_last  = !job_r.has_pts || (k_r == job_r.steps);
  assign pop_ready = (state_r == B_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (pop_valid) begin
        state_nxt = B_RUN;
      end
      B_RUN: if (advance && is_last) begin
        state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (advance) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && pop_valid) begin
      job_r   <= pop_job;
      acc_x_r <= ACC_W'(pop_job.newest_x) + ACC_W'(pop_job.dx);
      acc_y_r <= ACC_W'(pop_job.newest_y) + ACC_W'(pop_job.dy);
      k_r     <= CFG_W'(1);
    end else if (advance) begin
      acc_x_r <= acc_x_r + ACC_W'(job_r.dx);
      acc_y_r <= acc_y_r + ACC_W'(job_r.dy);
      k_r     <= k_r + 1'b1;
    end
    if (advance) begin
      x_r    <= job_r.has_pts ? sat32(acc_x_r) : '0;
      y_r    <= job_r.has_pts ? sat32(acc_y_r) : '0;
      ko_r   <= job_r.has_pts ? k_r : '0;
      has_r  <= job_r.has_pts;
      conf_r <= job_r.conf;
      last_r <= is_last;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_k     = ko_r;
  assign out_has   = has_r;
  assign out_conf  = conf_r;
  assign out_last  = last_r;

endmodule

// ===== design/constant_velocity_path_extrapolator.sv =====
// Top level of the constant-velocity path extrapolator: configuration
// registers, front end, job queue and back end. Uses cvpe_pkg.
//
// Each input word is one 2-D sample in Q16.16. The block keeps the two newest
// samples and a history count (saturating at 50; restart in tuser clears it
// first). With fewer than two samples held it returns one empty word with
// confidence 0. Otherwise it returns min(64, horizon_seconds * rate) points
// newest + k*(newest - previous), k = 1.., each saturated to 32 bits, or one
// empty word when that count is zero. Confidence is 2*count hundredths, halved
// when the squared speed does not exceed 0.25. A steps_per_second of 0 acts
// as 10. The front end takes a sample and works out its velocity, then does
// the rate multiply, the squares and the queue push before it takes another
// sample; the back end loads each job, then emits one result per cycle
// while the output is not stalled. A two-entry job queue lets the front end
// run ahead while the output is stalled. Configuration writes are always
// accepted and must only be made while the block is idle.
module constant_velocity_path_extrapolator
  import cvpe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input samples
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,   // [31:0] pos_x, [63:32] pos_y
  input  logic                 in_tuser,   // [0] restart
  // results
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [79:0]          out_tdata,  // [31:0] pred_x, [63:32] pred_y,
                                           // [70:64] step_index,
                                           // [77:71] confidence, [79:78] zero
  output logic                 out_tuser,  // [0] has_point
  output logic                 out_tlast,  // last_of_run
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,  // 0 steps_per_second, 1 horizon_seconds
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0] rate_r, horizon_r;

  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_job, pop_job;

  logic [POS_W-1:0] res_x, res_y;
  logic [CFG_W-1:0] res_k, res_conf;

  // Register file; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r    <= RESET_RATE;
      horizon_r <= RESET_HORIZON;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_STEPS_PER_SECOND: rate_r    <= cfg_data;
        REG_HORIZON_SECONDS:  horizon_r <= cfg_data;
        default: ;
      endcase
    end
  end

  cvpe_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_x        (in_tdata[31:0]),
    .in_y        (in_tdata[63:32]),
    .in_restart  (in_tuser),
    .rate_cfg    (rate_r),
    .horizon_cfg (horizon_r),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_job    (push_job)
  );

  cvpe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  cvpe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_x     (res_x),
    .out_y     (res_y),
    .out_k     (res_k),
    .out_has   (out_tuser),
    .out_conf  (res_conf),
    .out_last  (out_tlast)
  );

  assign out_tdata = {2'b00, res_conf, res_k, res_y, res_x};

endmodule

// ===== dv/cvpe_checker.sv =====
// Scoreboard for the constant-velocity path extrapolator: mirrors sample and
// register-write traffic, predicts every result word and compares it.
// Depends on cvpe_pkg only.
module cvpe_checker
  import cvpe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [63:0]          in_tdata,
  input  logic                 in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [79:0]          out_tdata,
  input  logic                 out_tuser,
  input  logic                 out_tlast,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   words_due,
  output int                   error_count
);

  localparam int     PRINT_CAP = 30;
  localparam longint POS_HI    = 2147483647;
  localparam longint POS_LO    = -POS_HI - 1;

  typedef struct packed {
    logic [POS_W-1:0] pred_x;
    logic [POS_W-1:0] pred_y;
    logic [CFG_W-1:0] step_index;
    logic             has_point;
    logic [CFG_W-1:0] confidence;
    logic             last_of_run;
  } point_word_t;

  point_word_t             predicted_words[$];
  logic [CFG_W-1:0]        rate_reg;
  logic [CFG_W-1:0]        horizon_reg;
  logic signed [POS_W-1:0] cur_x, cur_y, prev_x, prev_y;
  logic [CNT_W-1:0]        track_len;
  int                      words_checked;

  task automatic report(input string what, input logic [POS_W-1:0] got, want);
    if (error_count < PRINT_CAP) begin
      $display("%0t: word %0d %s: got %h want %h", $time, words_checked, what, got, want);
    end
    error_count++;
  endtask

  function automatic logic [POS_W-1:0] clamp32(input longint v);
    if (v > POS_HI) begin
      return POS_HI[POS_W-1:0];
    end
    if (v < POS_LO) begin
      return POS_LO[POS_W-1:0];
    end
    return v[POS_W-1:0];
  endfunction

  // Take in one sample and queue every word it should produce
  task automatic extrapolate(input logic [POS_W-1:0] sx, sy, input logic restart);
    longint          dx, dy;
    longint unsigned rate, span, dxa, dya;
    int              conf;
    bit              fast;
    point_word_t     w;
    if (restart) begin
      track_len = '0;
    end
    prev_x = cur_x;
    prev_y = cur_y;
    cur_x  = sx;
    cur_y  = sy;
    if (track_len < HISTORY_FULL) begin
      track_len++;
    end
    w = '0;
    if (track_len < 2) begin
      w.last_of_run = 1'b1;
      predicted_words.push_back(w);
      return;
    end

    rate = (rate_reg == '0) ? FALLBACK_RATE : rate_reg;
    dx   = longint'(cur_x) - longint'(prev_x);
    dy   = longint'(cur_y) - longint'(prev_y);
    dxa  = ((dx < 0) ? -dx : dx) * rate;
    dya  = ((dy < 0) ? -dy : dy) * rate;
    // either axis alone past half a unit/s settles it; else compare squares
    if (dxa > HALF_Q16 || dya > HALF_Q16) begin
      fast = 1'b1;
    end else begin
      fast = (dxa * dxa + dya * dya) > QUARTER_Q32;
    end

    conf = int'(track_len) * 100 / HISTORY_FULL;
    if (conf > 100) begin
      conf = 100;
    end
    if (!fast) begin
      conf = conf / 2;
    end
    w.confidence = CFG_W'(conf);

    span = horizon_reg * rate;
    if (span > MAX_STEPS) begin
      span = MAX_STEPS;
    end
    if (span == 0) begin
      w.last_of_run = 1'b1;
      predicted_words.push_back(w);
      return;
    end
    for (int k = 1; k <= int'(span); k++) begin
      w.pred_x      = clamp32(longint'(cur_x) + k * dx);
      w.pred_y      = clamp32(longint'(cur_y) + k * dy);
      w.step_index  = CFG_W'(k);
      w.has_point   = 1'b1;
      w.last_of_run = (k == int'(span));
      predicted_words.push_back(w);
    end
  endtask

  task automatic check_word();
    point_word_t want;
    if (predicted_words.size() == 0) begin
      report("arrived with nothing pending, pred_x", out_tdata[31:0], '0);
      return;
    end
    want = predicted_words.pop_front();
    if (out_tdata[31:0] !== want.pred_x) begin
      report("pred_x", out_tdata[31:0], want.pred_x);
    end
    if (out_tdata[63:32] !== want.pred_y) begin
      report("pred_y", out_tdata[63:32], want.pred_y);
    end
    if (out_tdata[70:64] !== want.step_index) begin
      report("step_index", POS_W'(out_tdata[70:64]), POS_W'(want.step_index));
    end
    if (out_tdata[77:71] !== want.confidence) begin
      report("confidence", POS_W'(out_tdata[77:71]), POS_W'(want.confidence));
    end
    if (out_tdata[79:78] !== 2'b00) begin
      report("pad bits", POS_W'(out_tdata[79:78]), '0);
    end
    if (out_tuser !== want.has_point) begin
      report("has_point", POS_W'(out_tuser), POS_W'(want.has_point));
    end
    if (out_tlast !== want.last_of_run) begin
      report("last_of_run", POS_W'(out_tlast), POS_W'(want.last_of_run));
    end
    words_checked++;
  endtask

  // Output before input: a word leaving at the same edge as a sample enters
  // always belongs to an older sample.
  always @(posedge clk) begin
    if (!rst_n) begin
      rate_reg    = RESET_RATE;
      horizon_reg = RESET_HORIZON;
      cur_x       = '0;
      cur_y       = '0;
      prev_x      = '0;
      prev_y      = '0;
      track_len   = '0;
      predicted_words.delete();
      words_due  <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_STEPS_PER_SECOND: rate_reg = cfg_data;
          REG_HORIZON_SECONDS:  horizon_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        check_word();
      end
      if (in_tvalid && in_tready) begin
        extrapolate(in_tdata[31:0], in_tdata[63:32], in_tuser);
      end
      words_due <= predicted_words.size();
    end
  end

endmodule

// ===== dv/tb_constant_velocity_path_extrapolator.sv =====
// Testbench top for the constant-velocity path extrapolator: clock, reset,
// sample and register stimulus, output back-pressure and the verdict.
// Depends on cvpe_pkg, the block and cvpe_checker.
module tb_constant_velocity_path_extrapolator;
  import cvpe_pkg::*;

  localparam int ITEM_TARGET = 270;
  localparam int IDLE_LIMIT  = 3000;   // cycles with no handshake at all

  localparam logic [POS_W-1:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [POS_W-1:0] POS_MIN = 32'h8000_0000;
  localparam logic [POS_W-1:0] ONE_Q16 = 32'h0001_0000;

  // register indexes the block does not decode; writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

  // velocity classes for generated tracks
  typedef enum int {
    HOVER,    // near the half-unit-per-second speed threshold
    CRUISE,   // moderate motion
    WILD,     // full 32-bit deltas, points clamp
    PARKED    // no motion at all
  } motion_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [63:0]          in_tdata   = '0;   // [31:0] pos_x, [63:32] pos_y
  logic                 in_tuser   = 1'b0; // [0] restart
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [79:0]          out_tdata;         // [31:0] pred_x, [63:32] pred_y,
                                           // [70:64] step_index,
                                           // [77:71] confidence, [79:78] zero
  logic                 out_tuser;         // [0] has_point
  logic                 out_tlast;         // last_of_run
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_data   = '0;

  int               words_due;
  int               error_count;
  int               samples_sent = 0;
  int               idle_cycles  = 0;
  int               ready_run    = 0;
  bit               smooth       = 1'b0;        // no gaps and no stalls while set
  logic [CFG_W-1:0] live_rate    = RESET_RATE;  // effective rate, scales HOVER speeds

  constant_velocity_path_extrapolator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  cvpe_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .words_due   (words_due),
    .error_count (error_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (smooth || r < 55) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Receiver: random runs of ready high and stalls of pick_gap length; always ready while smooth
  always @(posedge clk) begin
    if (smooth) begin
      out_tready <= 1'b1;
    end else if (ready_run > 0) begin
      ready_run <= ready_run - 1;
    end else if ($urandom_range(0, 2) != 0) begin
      out_tready <= 1'b1;
      ready_run  <= $urandom_range(0, 15);
    end else begin
      out_tready <= 1'b0;
      ready_run  <= pick_gap();
    end
  end

  // Watchdog: any accepted word on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold off the sender until every predicted word has come out. The first
  // edge is always waited so the checker's count covers the last sample.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
  endtask

  // One sample word. tvalid stays high across back-to-back words and is
  // only lowered when a gap is taken or a drain is waited for.
  task automatic send_sample(input logic [POS_W-1:0] x, y, input logic restart);
    int gap;
    if ($urandom_range(0, 59) == 0) begin
      wait_drained();
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {y, x};
    in_tuser  <= restart;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    samples_sent++;
  endtask

  // Register update, only with the block drained. Optionally slips in a
  // write to an undecoded index, which must leave both registers alone.
  task automatic write_regs(input logic [CFG_W-1:0] rate, hor, input bit spare);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= REG_STEPS_PER_SECOND;
    cfg_data  <= rate;
    do @(posedge clk); while (!cfg_ready);
    if (spare) begin
      cfg_index <= ($urandom_range(0, 1) != 0) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI;
      cfg_data  <= CFG_W'($urandom);
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_index <= REG_HORIZON_SECONDS;
    cfg_data  <= hor;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    live_rate = (rate == '0) ? FALLBACK_RATE : rate;
  endtask

  initial begin
    logic [POS_W-1:0] px, py, vx, vy;
    int               seg_end, len;
    motion_t          kind;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    // reset settings (rate 10, horizon 3 -> 30 points)
    send_sample('0, '0, 1'b0);              // single sample: empty word
    send_sample(ONE_Q16, '0, 1'b0);         // one unit per frame, fast
    send_sample(POS_MAX, POS_MIN, 1'b1);    // restart: empty again
    send_sample(POS_MIN, POS_MAX, 1'b0);    // full-scale delta, clamps both ways

    // rate 1, zero horizon: one pointless word carrying confidence
    write_regs(7'd1, 7'd0, 1'b1);
    send_sample('0, '0, 1'b0);
    send_sample('0, '0, 1'b0);              // standing still, halved
    send_sample(32'd32768, '0, 1'b0);       // exactly 0.5 u/s: still slow
    send_sample(32'd65537, '0, 1'b0);       // one LSB over: fast

    // rate 0 falls back to 10, horizon 1 -> 10 points
    write_regs(7'd0, 7'd1, 1'b0);
    send_sample(32'd68814, '0, 1'b0);       // 3277*10 just over half
    send_sample(32'd72090, '0, 1'b0);       // 3276*10 just under
    send_sample(32'd74408, 32'd2318, 1'b0); // diagonal, sum of squares over
    send_sample(32'd76725, 32'd4635, 1'b0); // diagonal, sum of squares under

    // oversized rate and horizon: point count caps at 64
    write_regs(7'd127, 7'd127, 1'b1);
    send_sample(POS_MAX, POS_MAX, 1'b1);
    send_sample(32'h7fff_fffe, 32'h7fff_fffe, 1'b0);
    send_sample('0, POS_MAX, 1'b0);

    write_regs(7'd64, 7'd1, 1'b0);
    send_sample(POS_MIN, POS_MIN, 1'b0);

    write_regs(7'd1, 7'd64, 1'b0);
    send_sample(ONE_Q16, POS_MIN, 1'b1);
    send_sample('0, '0, 1'b0);

    write_regs(7'd7, 7'd2, 1'b1);
    send_sample(32'hffff_0000, 32'h0000_8000, 1'b0);

    // --- random: segments of tracks and noise, one setting per segment ---
    while (samples_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        // corner settings: rate 0/1/8/64/127 against horizon 0/1/64/127
        write_regs(CFG_W'($urandom_range(0, 3) == 0 ? 0 : 1 << (3 * $urandom_range(0, 2))) |
                     ($urandom_range(0, 3) == 0 ? CFG_W'(127) : CFG_W'(0)),
                   ($urandom_range(0, 1) != 0) ? CFG_W'($urandom_range(0, 1)) :
                     (($urandom_range(0, 1) != 0) ? CFG_W'(64) : CFG_W'(127)),
                   $urandom_range(0, 1) != 0);
      end else begin
        // keep runs short most of the time
        write_regs(CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(0, 3)),
                   $urandom_range(0, 3) == 0);
      end
      smooth  <= ($urandom_range(0, 4) == 0);
      seg_end = samples_sent + $urandom_range(15, 45);

      while (samples_sent < seg_end && samples_sent < ITEM_TARGET) begin
        if ($urandom_range(0, 9) < 2) begin
          // noise: any position, restart at random
          send_sample($urandom, $urandom, 1'($urandom_range(0, 1)));
        end else begin
          // now and then a track long enough to saturate the history count
          len  = ($urandom_range(0, 11) == 0) ? $urandom_range(51, 60) :
                                                $urandom_range(2, 10);
          kind = motion_t'($urandom_range(0, 3));
          px   = $urandom;
          py   = $urandom;
          case (kind)
            HOVER: begin
              vx = $urandom_range(0, 65536 / live_rate);
              vy = $urandom_range(0, 65536 / live_rate);
            end
            CRUISE: begin
              vx = $urandom_range(0, 1 << 20);
              vy = $urandom_range(0, 1 << 20);
            end
            WILD: begin
              vx = $urandom;
              vy = $urandom;
            end
            default: begin
              vx = '0;
              vy = '0;
            end
          endcase
          if ($urandom_range(0, 1) != 0) begin
            vx = -vx;
          end
          if ($urandom_range(0, 1) != 0) begin
            vy = -vy;
          end
          for (int i = 0; i < len && samples_sent < ITEM_TARGET; i++) begin
            send_sample(px, py, i == 0);
            px += vx;
            py += vy;
          end
        end
      end
    end

    // drain, then give the block time to show any stray word
    smooth <= 1'b0;
    wait_drained();
    repeat (2 * MAX_STEPS) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== constant_velocity_path_extrapolator.f =====
design/cvpe_pkg.sv
design/cvpe_front.sv
design/cvpe_queue.sv
design/cvpe_back.sv
design/constant_velocity_path_extrapolator.sv
dv/cvpe_checker.sv
dv/tb_constant_velocity_path_extrapolator.sv
